>>> src/ddic_pkg.sv
// ----------------------------------------------------------------------------
// ddic_pkg: shared types and a function for the disk DMA interrupt controller
// Operation codes, the classified request record, and the priority encoder.
// ----------------------------------------------------------------------------
package ddic_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned REQ_W = 14;
    localparam int unsigned ENA_W = 15;
    localparam int unsigned LEN_COUNT_W = 14;

    localparam logic [13:0] BLOCK_DONE_BIT = 14'h0002;
    localparam int unsigned MASTER_IDX = 14;
    localparam int unsigned SET_CLEAR_IDX = 15;

    typedef enum logic [2:0] {
        OP_REQ_WR  = 3'd0,
        OP_ENA_WR  = 3'd1,
        OP_PTR_HI  = 3'd2,
        OP_PTR_LO  = 3'd3,
        OP_LEN_WR  = 3'd4,
        OP_DISK_WD = 3'd5,
        OP_RAISE   = 3'd6,
        OP_IDLE    = 3'd7
    } t_op;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic        req_wr;
        logic        ena_wr;
        logic        ptr_hi;
        logic        ptr_lo;
        logic        len_wr;
        logic        disk_wd;
        logic        raise;
        logic        allowed;
        logic [15:0] data;
    } t_cmd;

    localparam int unsigned CMD_W = $bits(t_cmd);

    function automatic logic [2:0] prio_level(input logic master,
                                              input logic [13:0] pend);
        logic [2:0] lvl;
        begin
            if (!master) begin
                lvl = 3'd0;
            end else if (pend[13]) begin
                lvl = 3'd6;
            end else if (|pend[12:11]) begin
                lvl = 3'd5;
            end else if (|pend[10:7]) begin
                lvl = 3'd4;
            end else if (|pend[6:4]) begin
                lvl = 3'd3;
            end else if (pend[3]) begin
                lvl = 3'd2;
            end else if (|pend[2:0]) begin
                lvl = 3'd1;
            end else begin
                lvl = 3'd0;
            end
            return lvl;
        end
    endfunction

endpackage

>>> src/ddic_front.sv
// ----------------------------------------------------------------------------
// ddic_front: request intake and classification
// Decodes the operation code into per-action flags for the execution side.
// ----------------------------------------------------------------------------
module ddic_front (
    input  logic              i_in_valid,
    input  logic [2:0]        i_op,
    input  logic [15:0]       i_data,
    input  logic              i_disk_dma_on,
    input  logic              i_q_full,
    output logic              o_in_stall,
    output logic              o_push,
    output ddic_pkg::t_cmd    o_cmd
);
    import ddic_pkg::*;

    t_op op;

    assign op         = t_op'(i_op);
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd         = '0;
        o_cmd.data    = i_data;
        o_cmd.allowed = i_disk_dma_on;
        case (op)
            OP_REQ_WR:  o_cmd.req_wr  = 1'b1;
            OP_ENA_WR:  o_cmd.ena_wr  = 1'b1;
            OP_PTR_HI:  o_cmd.ptr_hi  = 1'b1;
            OP_PTR_LO:  o_cmd.ptr_lo  = 1'b1;
            OP_LEN_WR:  o_cmd.len_wr  = 1'b1;
            OP_DISK_WD: o_cmd.disk_wd = 1'b1;
            OP_RAISE:   o_cmd.raise   = 1'b1;
            OP_IDLE:    o_cmd.data    = i_data;
            default:    o_cmd.data    = i_data;
        endcase
    end

endmodule

>>> src/ddic_queue.sv
// ----------------------------------------------------------------------------
// ddic_queue: short request queue between the front and the back
// A small circular buffer of classified requests with a fill count.
// ----------------------------------------------------------------------------
module ddic_queue #(
    parameter int unsigned DEPTH = ddic_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ddic_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output ddic_pkg::t_cmd    o_cmd
);
    import ddic_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          push_ok, pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        n_count = r_count + CW'(push_ok) - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> src/ddic_back.sv
// ----------------------------------------------------------------------------
// ddic_back: request execution and result register
// Holds the interrupt, pointer, length and DMA state and registers results.
// ----------------------------------------------------------------------------
module ddic_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  ddic_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_ipl_level,
    output logic [13:0]       o_request_value,
    output logic [14:0]       o_enable_value,
    output logic              o_mem_write,
    output logic [31:0]       o_mem_address,
    output logic [15:0]       o_mem_data,
    output logic              o_disk_busy
);
    import ddic_pkg::*;

    logic [REQ_W-1:0]       r_req, n_req;
    logic [ENA_W-1:0]       r_ena, n_ena;
    logic [31:0]            r_ptr, n_ptr;
    logic [15:0]            r_len, n_len;
    logic                   r_run, n_run;
    logic                   r_out_valid;
    logic [2:0]             r_ipl;
    logic                   r_wr;
    logic [31:0]            r_addr;
    logic [15:0]            r_wdata;
    logic                   n_wr;
    logic [31:0]            n_addr;
    logic [15:0]            n_wdata;
    logic [LEN_COUNT_W-1:0] count;
    logic                   set_bit;

    // The result register frees up when it is empty or being taken.
    assign o_pop   = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign set_bit = i_cmd.data[SET_CLEAR_IDX];
    assign count   = r_len[LEN_COUNT_W-1:0] - LEN_COUNT_W'(1);

    always_comb begin
        n_req   = r_req;
        n_ena   = r_ena;
        n_ptr   = r_ptr;
        n_len   = r_len;
        n_run   = r_run;
        n_wr    = 1'b0;
        n_addr  = '0;
        n_wdata = '0;
        if (i_cmd.req_wr) begin
            n_req = set_bit ? (r_req | i_cmd.data[REQ_W-1:0])
                            : (r_req & ~i_cmd.data[REQ_W-1:0]);
        end
        if (i_cmd.ena_wr) begin
            n_ena = set_bit ? (r_ena | i_cmd.data[ENA_W-1:0])
                            : (r_ena & ~i_cmd.data[ENA_W-1:0]);
        end
        if (i_cmd.ptr_hi) begin
            n_ptr = {i_cmd.data, r_ptr[15:0]};
        end
        if (i_cmd.ptr_lo) begin
            n_ptr = {r_ptr[31:16], i_cmd.data};
        end
        if (i_cmd.len_wr) begin
            // DMA starts on the second consecutive length write with the flag set, if allowed.
            if (r_len[SET_CLEAR_IDX] && set_bit && i_cmd.allowed) begin
                n_run = 1'b1;
            end
            n_len = i_cmd.data;
        end
        if (i_cmd.disk_wd && r_run) begin
            n_wr    = 1'b1;
            n_addr  = r_ptr;
            n_wdata = i_cmd.data;
            n_len   = {r_len[15:LEN_COUNT_W], count};
            n_ptr   = r_ptr + 32'd2;
            if (count == '0) begin
                n_run = 1'b0;
                n_req = r_req | BLOCK_DONE_BIT;
            end
        end
        if (i_cmd.raise) begin
            n_req = r_req | i_cmd.data[REQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req       <= '0;
            r_ena       <= '0;
            r_ptr       <= '0;
            r_len       <= '0;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_req <= n_req;
                r_ena <= n_ena;
                r_ptr <= n_ptr;
                r_len <= n_len;
                r_run <= n_run;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ipl   <= prio_level(n_ena[MASTER_IDX], n_ena[REQ_W-1:0] & n_req);
            r_wr    <= n_wr;
            r_addr  <= n_addr;
            r_wdata <= n_wdata;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ipl_level     = r_ipl;
    assign o_request_value = r_req;
    assign o_enable_value  = r_ena;
    assign o_mem_write     = r_wr;
    assign o_mem_address   = r_addr;
    assign o_mem_data      = r_wdata;
    assign o_disk_busy     = r_run;

endmodule

>>> src/disk_dma_and_interrupt_controller_top.sv
// ----------------------------------------------------------------------------
// disk_dma_and_interrupt_controller_top: interrupt priority and disk DMA
// Set/clear interrupt request and enable registers with a disk DMA engine.
// ----------------------------------------------------------------------------
// Path: an accepted request is written into the request queue, then popped
// into the result register that drives the outputs.
// Throughput: one request per cycle while the output is not stalled; the queue
// of QUEUE_DEPTH entries absorbs output stalls before the input stalls.
// Reset: synchronous, clears all interrupt, pointer, length and DMA state.
module disk_dma_and_interrupt_controller_top #(
    parameter int unsigned QUEUE_DEPTH = ddic_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_data,
    input  logic        i_disk_dma_on,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_ipl_level,
    output logic [13:0] o_request_value,
    output logic [14:0] o_enable_value,
    output logic        o_mem_write,
    output logic [31:0] o_mem_address,
    output logic [15:0] o_mem_data,
    output logic        o_disk_busy
);
    import ddic_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    ddic_front u_front (
        .i_in_valid    (i_in_valid),
        .i_op          (i_op),
        .i_data        (i_data),
        .i_disk_dma_on (i_disk_dma_on),
        .i_q_full      (q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    ddic_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (queue_cmd)
    );

    ddic_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_cmd           (queue_cmd),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ipl_level     (o_ipl_level),
        .o_request_value (o_request_value),
        .o_enable_value  (o_enable_value),
        .o_mem_write     (o_mem_write),
        .o_mem_address   (o_mem_address),
        .o_mem_data      (o_mem_data),
        .o_disk_busy     (o_disk_busy)
    );

    // A nonzero level requires the master enable.
    a_ipl_master: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_ipl_level != 3'd0) |-> o_enable_value[MASTER_IDX])
        else $error("interrupt level raised without master enable");

    // The top level is only reached through request bit 13 enabled.
    a_ipl_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_ipl_level == 3'd6) |->
            o_request_value[13] && o_enable_value[13])
        else $error("level 6 without enabled request bit 13");

    // Memory fields are quiet on results without a memory write.
    a_mem_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_mem_write |->
            (o_mem_address == 32'd0) && (o_mem_data == 16'd0))
        else $error("memory fields driven without a write");

    // A request entering the empty pipeline is queued, then popped, and then
    // seen as a valid result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && q_empty && !o_out_valid |=> ##1 o_out_valid)
        else $error("result missing after an idle-pipeline request");

endmodule

>>> tb/tb_disk_dma_and_interrupt_controller_top.sv
// ----------------------------------------------------------------------------
// tb_disk_dma_and_interrupt_controller_top: self-checking bench for the block
// Drives register writes, raises and disk word ticks through the request
// channel with random gaps and output stalls. Each accepted request is run
// through a local copy of the interrupt and DMA state. Every result is then
// compared field by field with the predicted status.
// ----------------------------------------------------------------------------
module tb_disk_dma_and_interrupt_controller_top;

    import ddic_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int RANDOM_TARGET   = 1750;
    localparam int CALM_TAIL       = 200;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct {
        t_op         op;
        logic [15:0] data;
        logic        dma_on;
    } t_disk_irq_request;

    typedef struct {
        logic [2:0]  ipl;
        logic [13:0] req;
        logic [14:0] ena;
        logic        wr;
        logic [31:0] addr;
        logic [15:0] wdata;
        logic        busy;
    } t_controller_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_op = OP_IDLE;
    logic [15:0] i_data = 16'h0000;
    logic        i_disk_dma_on = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_ipl_level;
    logic [13:0] o_request_value;
    logic [14:0] o_enable_value;
    logic        o_mem_write;
    logic [31:0] o_mem_address;
    logic [15:0] o_mem_data;
    logic        o_disk_busy;

    disk_dma_and_interrupt_controller_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_data          (i_data),
        .i_disk_dma_on   (i_disk_dma_on),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ipl_level     (o_ipl_level),
        .o_request_value (o_request_value),
        .o_enable_value  (o_enable_value),
        .o_mem_write     (o_mem_write),
        .o_mem_address   (o_mem_address),
        .o_mem_data      (o_mem_data),
        .o_disk_busy     (o_disk_busy)
    );

    t_disk_irq_request  pending_requests[$];
    t_controller_status expected_status[$];

    // Predicted controller state.
    logic [13:0] req_bits = '0;
    logic [14:0] ena_bits = '0;
    logic [31:0] disk_ptr = '0;
    logic [15:0] len_reg = '0;
    logic        xfer_active = 1'b0;

    int total_requests = 0;
    int accepted_count = 0;
    int results_seen = 0;
    int errors = 0;
    int words_written = 0;
    int blocks_done = 0;
    int max_level = 0;

    t_disk_irq_request  presented;
    t_controller_status predicted;
    t_controller_status want;
    int   gap_left = 0;
    int   gap_pct = 10;
    int   stall_left = 0;
    int   stall_pct = 10;
    int   monitor_cycles = 0;
    int   quiet_cycles = 0;
    logic calm = 1'b0;

    function automatic logic [2:0] irq_level(input logic [14:0] ena, input logic [13:0] req);
        logic [13:0] pend;
        pend = ena[13:0] & req;
        if (!ena[MASTER_IDX]) return 3'd0;
        if (pend[13]) return 3'd6;
        if (pend[12] || pend[11]) return 3'd5;
        if (pend[10:7] != 4'b0) return 3'd4;
        if (pend[6:4] != 3'b0) return 3'd3;
        if (pend[3]) return 3'd2;
        if (pend[2:0] != 3'b0) return 3'd1;
        return 3'd0;
    endfunction

    task automatic advance_controller(input t_disk_irq_request rq,
                                      output t_controller_status st);
        logic [13:0] count;
        st.wr = 1'b0;
        st.addr = 32'h0;
        st.wdata = 16'h0;
        case (rq.op)
            OP_REQ_WR: begin
                if (rq.data[SET_CLEAR_IDX]) req_bits = req_bits | rq.data[13:0];
                else req_bits = req_bits & ~rq.data[13:0];
            end
            OP_ENA_WR: begin
                if (rq.data[SET_CLEAR_IDX]) ena_bits = ena_bits | rq.data[14:0];
                else ena_bits = ena_bits & ~rq.data[14:0];
            end
            OP_PTR_HI: disk_ptr[31:16] = rq.data;
            OP_PTR_LO: disk_ptr[15:0] = rq.data;
            OP_LEN_WR: begin
                // Start needs bit 15 in both the old and the new length value.
                if (len_reg[SET_CLEAR_IDX] && rq.data[SET_CLEAR_IDX] && rq.dma_on)
                    xfer_active = 1'b1;
                len_reg = rq.data;
            end
            OP_DISK_WD: begin
                if (xfer_active) begin
                    count = len_reg[13:0] - 14'd1;
                    st.wr = 1'b1;
                    st.addr = disk_ptr;
                    st.wdata = rq.data;
                    len_reg[13:0] = count;
                    disk_ptr = disk_ptr + 32'd2;
                    words_written++;
                    if (count == 14'd0) begin
                        xfer_active = 1'b0;
                        req_bits = req_bits | BLOCK_DONE_BIT;
                        blocks_done++;
                    end
                end
            end
            OP_RAISE: req_bits = req_bits | rq.data[13:0];
            default: ;
        endcase
        st.ipl = irq_level(ena_bits, req_bits);
        st.req = req_bits;
        st.ena = ena_bits;
        st.busy = xfer_active;
        if (int'(st.ipl) > max_level) max_level = int'(st.ipl);
    endtask

    task automatic queue_request(input t_op op, input logic [15:0] d, input logic on);
        t_disk_irq_request rq;
        rq.op = op;
        rq.data = d;
        rq.dma_on = on;
        pending_requests.push_back(rq);
    endtask

    // Sparse set/clear traffic on the request and enable registers, with raises and idles.
    task automatic queue_irq_op();
        logic [15:0] d;
        int sel;
        sel = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) d = 16'($urandom);
        else d = 16'($urandom & $urandom & $urandom);
        d[SET_CLEAR_IDX] = 1'($urandom_range(0, 1));
        if (sel < 4) begin
            queue_request(OP_REQ_WR, d, 1'($urandom));
        end else if (sel < 7) begin
            if (d[SET_CLEAR_IDX] && $urandom_range(0, 1) == 1) d[MASTER_IDX] = 1'b1;
            queue_request(OP_ENA_WR, d, 1'($urandom));
        end else if (sel < 9) begin
            queue_request(OP_RAISE, d, 1'($urandom));
        end else begin
            queue_request(OP_IDLE, d, 1'($urandom));
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Driver: presents queued requests, holds them while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                advance_controller(presented, predicted);
                expected_status.push_back(predicted);
                accepted_count++;
                if (accepted_count % 64 == 0) begin
                    case ($urandom_range(0, 3))
                        0: gap_pct = 0;
                        1: gap_pct = 5;
                        2: gap_pct = 15;
                        default: gap_pct = 35;
                    endcase
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    presented = pending_requests.pop_front();
                    i_op <= presented.op;
                    i_data <= presented.data;
                    i_disk_dma_on <= presented.dma_on;
                    i_in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 99) < gap_pct)
                        gap_left = $urandom_range(1, 19);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            calm <= (pending_requests.size() < CALM_TAIL);
        end
    end

    // Monitor: checks each accepted result and generates output stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_status.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d arrived with no request outstanding",
                                 results_seen);
                end else begin
                    want = expected_status.pop_front();
                    if (o_ipl_level !== want.ipl || o_request_value !== want.req ||
                        o_enable_value !== want.ena || o_mem_write !== want.wr ||
                        o_mem_address !== want.addr || o_mem_data !== want.wdata ||
                        o_disk_busy !== want.busy) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch on result %0d", results_seen);
                            $display("  exp ipl=%0d req=%h ena=%h wr=%b addr=%h data=%h busy=%b",
                                     want.ipl, want.req, want.ena, want.wr, want.addr,
                                     want.wdata, want.busy);
                            $display("  got ipl=%0d req=%h ena=%h wr=%b addr=%h data=%h busy=%b",
                                     o_ipl_level, o_request_value, o_enable_value,
                                     o_mem_write, o_mem_address, o_mem_data, o_disk_busy);
                        end
                    end
                end
            end
            monitor_cycles++;
            if (monitor_cycles % 256 == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 4;
                    2: stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 19) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("no handshake for %0d cycles, %0d results still outstanding",
                     quiet_cycles, expected_status.size());
            $display("[disk_dma_and_interrupt_controller_top] ERROR");
            $finish;
        end
    end

    initial begin
        int kind;
        int n;
        int words;
        int k;
        logic [15:0] lw;
        logic zero_start;

        // Directed: level steps, set/clear edges, pointer wrap, DMA corner cases.
        queue_request(OP_IDLE,    16'h0000, 1'b0);
        queue_request(OP_REQ_WR,  16'hFFFF, 1'b0);
        queue_request(OP_ENA_WR,  16'hFFFF, 1'b1);
        queue_request(OP_REQ_WR,  16'h2000, 1'b0);
        queue_request(OP_REQ_WR,  16'h1800, 1'b0);
        queue_request(OP_REQ_WR,  16'h0780, 1'b0);
        queue_request(OP_REQ_WR,  16'h0070, 1'b0);
        queue_request(OP_REQ_WR,  16'h0008, 1'b0);
        queue_request(OP_REQ_WR,  16'h7FFF, 1'b1);
        queue_request(OP_RAISE,   16'hFFFF, 1'b0);
        queue_request(OP_ENA_WR,  16'h4000, 1'b0);
        queue_request(OP_ENA_WR,  16'hC000, 1'b0);
        queue_request(OP_ENA_WR,  16'h3FFD, 1'b0);
        queue_request(OP_REQ_WR,  16'h3FFF, 1'b0);
        queue_request(OP_PTR_HI,  16'hFFFF, 1'b0);
        queue_request(OP_PTR_LO,  16'hFFFE, 1'b1);
        queue_request(OP_DISK_WD, 16'hA5A5, 1'b1);
        queue_request(OP_LEN_WR,  16'h8003, 1'b1);
        queue_request(OP_LEN_WR,  16'h8003, 1'b0);
        queue_request(OP_LEN_WR,  16'hC003, 1'b1);
        // Allowance low mid-transfer, the pointer wraps, and the count is rewritten.
        queue_request(OP_DISK_WD, 16'hFFFF, 1'b0);
        queue_request(OP_LEN_WR,  16'h8001, 1'b0);
        queue_request(OP_DISK_WD, 16'h0000, 1'b0);
        // Zero length start wraps the count; a rewrite then ends it early.
        queue_request(OP_LEN_WR,  16'h8000, 1'b1);
        queue_request(OP_DISK_WD, 16'h1234, 1'b1);
        queue_request(OP_LEN_WR,  16'h0001, 1'b0);
        queue_request(OP_DISK_WD, 16'hFFFF, 1'b1);

        while (pending_requests.size() < RANDOM_TARGET + 27) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                // A transfer: maybe a pointer, two length writes, then disk words.
                zero_start = ($urandom_range(0, 14) == 0);
                if (zero_start) n = 0;
                else if ($urandom_range(0, 9) == 0) n = $urandom_range(9, 40);
                else n = $urandom_range(1, 6);
                if ($urandom_range(0, 4) != 0) begin
                    queue_request(OP_PTR_HI, 16'($urandom), 1'($urandom));
                    queue_request(OP_PTR_LO, 16'($urandom), 1'($urandom));
                end
                lw = {1'b1, 1'($urandom), 14'(n)};
                queue_request(OP_LEN_WR, lw, 1'($urandom));
                // Some sequences are broken: no allowance or a clear bit 15.
                case ($urandom_range(0, 7))
                    0: queue_request(OP_LEN_WR, lw, 1'b0);
                    1: queue_request(OP_LEN_WR, lw & 16'h7FFF, 1'b1);
                    default: queue_request(OP_LEN_WR, lw, 1'b1);
                endcase
                words = zero_start ? 1 : n + $urandom_range(0, 2);
                k = 0;
                while (k < words) begin
                    queue_request(OP_DISK_WD, 16'($urandom), 1'($urandom));
                    if (k == 0 && zero_start) begin
                        n = $urandom_range(1, 4);
                        queue_request(OP_LEN_WR, {1'($urandom), 1'($urandom), 14'(n)},
                                      1'($urandom));
                        words = words + n;
                    end else if ($urandom_range(0, 29) == 0) begin
                        n = $urandom_range(1, 3);
                        queue_request(OP_LEN_WR, {1'($urandom), 1'($urandom), 14'(n)},
                                      1'($urandom));
                        words = k + 1 + n;
                    end
                    if ($urandom_range(0, 4) == 0) queue_irq_op();
                    k++;
                end
            end else if (kind < 80) begin
                repeat ($urandom_range(4, 10)) queue_irq_op();
            end else begin
                repeat ($urandom_range(1, 6))
                    queue_request(t_op'($urandom_range(0, 7)), 16'($urandom), 1'($urandom));
            end
        end
        total_requests = pending_requests.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_requests) @(posedge i_clk);
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d of %0d requests; %0d disk words went to memory",
                 results_seen, total_requests, words_written);
        $display("%0d transfers completed, highest priority level seen %0d, %0d mismatches",
                 blocks_done, max_level, errors);
        if (errors == 0 && expected_status.size() == 0) begin
            $display("[disk_dma_and_interrupt_controller_top] OK");
        end else begin
            $display("[disk_dma_and_interrupt_controller_top] ERROR");
        end
        $finish;
    end

endmodule
